// File: src/sfn_pkg.sv
// shared constants, types and exp table for the softmax normalizer
package sfn_pkg;

    localparam int MAX_CLASSES_DEF = 32;
    localparam int SCORE_W = 16;
    localparam int PROB_W = 16;
    localparam int E_W = 17;
    localparam int NUM_W = 33;
    localparam int QUO_W = 17;
    localparam logic [16:0] LOG2E_Q16 = 17'd94548;
    localparam logic [SCORE_W-1:0] SCORE_MIN = 16'h8000;

    typedef struct packed {
        logic            valid;
        logic [E_W-1:0]  value;
    } exp_res_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    function automatic logic [16:0] pow2_frac(input logic [4:0] k);
        logic [16:0] v;
        begin
            case (k)
                5'd0:    v = 17'd65536;
                5'd1:    v = 17'd62757;
                5'd2:    v = 17'd60097;
                5'd3:    v = 17'd57549;
                5'd4:    v = 17'd55109;
                5'd5:    v = 17'd52773;
                5'd6:    v = 17'd50535;
                5'd7:    v = 17'd48393;
                5'd8:    v = 17'd46341;
                5'd9:    v = 17'd44376;
                5'd10:   v = 17'd42495;
                5'd11:   v = 17'd40693;
                5'd12:   v = 17'd38968;
                5'd13:   v = 17'd37316;
                5'd14:   v = 17'd35734;
                5'd15:   v = 17'd34219;
                5'd16:   v = 17'd32768;
                default: v = 17'd32768;
            endcase
            return v;
        end
    endfunction

endpackage

// File: src/sfn_exp_unit.sv
// two-stage pipelined exp approximation of a non-positive score difference
module sfn_exp_unit
    import sfn_pkg::*;
#(
    parameter int AW = 5
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_vld,
    input  logic [SCORE_W-1:0] in_score,
    input  logic [SCORE_W-1:0] in_max,
    input  logic [AW-1:0]      in_addr,
    output exp_res_t           res,
    output logic [AW-1:0]      res_addr,
    output logic               busy
);

    logic              s1_valid_reg;
    logic [16:0]       s1_y_reg;
    logic [AW-1:0]     s1_addr_reg;
    logic              s2_valid_reg;
    logic [E_W-1:0]    s2_e_reg;
    logic [AW-1:0]     s2_addr_reg;

    logic [16:0]       diff;
    logic [32:0]       prod;
    logic [32:0]       y_full;
    logic [16:0]       y_next;

    logic [16:0]       t_hi;
    logic [16:0]       t_lo;
    logic [16:0]       t_dlt;
    logic [15:0]       slope;
    logic [16:0]       m_val;
    logic [8:0]        n_val;
    logic [E_W-1:0]    e_next;

    // stage 1: x = max - score, scaled by log2(e)
    always_comb
    begin
        diff   = {in_max[SCORE_W-1], in_max} - {in_score[SCORE_W-1], in_score};
        prod   = 33'(diff[15:0]) * 33'(LOG2E_Q16);
        y_full = prod + 33'd32768;
        y_next = y_full[32:16];
    end

    // stage 2: table interpolation and shift
    always_comb
    begin
        t_hi   = pow2_frac({1'b0, s1_y_reg[7:4]});
        t_lo   = pow2_frac({1'b0, s1_y_reg[7:4]} + 5'd1);
        t_dlt  = t_hi - t_lo;
        slope  = 16'(t_dlt[11:0]) * 16'(s1_y_reg[3:0]);
        m_val  = t_hi - {5'd0, slope[15:4]};
        n_val  = s1_y_reg[16:8];
        if (n_val >= 9'd32)
            e_next = '0;
        else
            e_next = m_val >> n_val[4:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_vld;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_y_reg    <= y_next;
        s1_addr_reg <= in_addr;
        s2_e_reg    <= e_next;
        s2_addr_reg <= s1_addr_reg;
    end

    assign res.valid = s2_valid_reg;
    assign res.value = s2_e_reg;
    assign res_addr  = s2_addr_reg;
    assign busy      = s1_valid_reg | s2_valid_reg;

endmodule

// File: src/sfn_divider.sv
// radix-2 restoring divider, one quotient bit per cycle, saturating result
module sfn_divider
    import sfn_pkg::*;
#(
    parameter int SUM_W = 22
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [NUM_W-1:0]  num,
    input  logic [SUM_W-1:0]  den,
    output div_stat_t         stat,
    output logic [PROB_W-1:0] quotient
);

    localparam int STEP_W = $clog2(QUO_W + 1);

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              done_reg;
    logic              done_next;
    logic [SUM_W-1:0]  rem_reg;
    logic [SUM_W-1:0]  rem_next;
    logic [QUO_W-1:0]  low_reg;
    logic [QUO_W-1:0]  low_next;
    logic [QUO_W-1:0]  quo_reg;
    logic [QUO_W-1:0]  quo_next;
    logic [SUM_W-1:0]  den_reg;
    logic [SUM_W-1:0]  den_next;
    logic [SUM_W:0]    trial;

    always_comb
    begin
        step_next = step_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        low_next  = low_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        trial     = {rem_reg, low_reg[QUO_W-1]};
        if (start)
        begin
            rem_next  = SUM_W'(num[NUM_W-1:QUO_W]);
            low_next  = num[QUO_W-1:0];
            den_next  = den;
            quo_next  = '0;
            step_next = STEP_W'(QUO_W);
        end
        else if (step_reg != '0)
        begin
            low_next = {low_reg[QUO_W-2:0], 1'b0};
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = SUM_W'(trial - {1'b0, den_reg});
                quo_next = {quo_reg[QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[SUM_W-1:0];
                quo_next = {quo_reg[QUO_W-2:0], 1'b0};
            end
            step_next = step_reg - 1'b1;
            done_next = (step_reg == STEP_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        low_reg <= low_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign stat.busy = (step_reg != '0);
    assign stat.done = done_reg;
    assign quotient  = quo_reg[QUO_W-1] ? {PROB_W{1'b1}} : quo_reg[PROB_W-1:0];

endmodule

// File: src/softmax_normalizer_top.sv
// softmax normalizer: score and exp memories, pass sequencer, output register
// loading takes one score beat per cycle into the score memory
// after the last beat, the exp pass reads the score memory once per entry
// each probability then comes from the exp memory read and the one-bit-per-cycle divider;
// the input is not ready from the last beat until the final result
// reset clears count, maximum, sequencer and output valid; memory contents stay undefined
module softmax_normalizer_top
    import sfn_pkg::*;
#(
    parameter int MAX_CLASSES = MAX_CLASSES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               score_valid,
    output logic               score_ready,
    input  logic [SCORE_W-1:0] score,
    input  logic               last,
    output logic               prob_valid,
    input  logic               prob_ready,
    output logic [PROB_W-1:0]  probability,
    output logic               final_res
);

    localparam int AW    = $clog2(MAX_CLASSES);
    localparam int CNT_W = $clog2(MAX_CLASSES + 1);
    localparam int SUM_W = $clog2(MAX_CLASSES) + 17;

    typedef enum logic [5:0] {
        ST_LOAD  = 6'b000001,
        ST_EXP   = 6'b000010,
        ST_RD    = 6'b000100,
        ST_START = 6'b001000,
        ST_RUN   = 6'b010000,
        ST_EMIT  = 6'b100000
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [SCORE_W-1:0] max_reg, max_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic               rd_valid_reg, rd_valid_next;
    logic [AW-1:0]      rd_addr_reg, rd_addr_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [PROB_W-1:0]  prob_reg, prob_next;
    logic               final_reg, final_next;
    logic               out_valid_reg, out_valid_next;

    logic [SCORE_W-1:0] score_mem [MAX_CLASSES];
    logic [E_W-1:0]     exp_mem [MAX_CLASSES];
    logic [SCORE_W-1:0] score_q_reg;
    logic [E_W-1:0]     exp_q_reg;

    logic               in_fire;
    logic               has_room;
    logic [CNT_W-1:0]   new_count;
    logic               emit_fire;
    logic               is_final;
    logic               div_start;
    logic [NUM_W-1:0]   div_num;

    exp_res_t           exp_res;
    logic [AW-1:0]      exp_addr;
    logic               exp_busy;
    div_stat_t          div_stat;
    logic [PROB_W-1:0]  div_quo;

    assign score_ready = (state_reg == ST_LOAD);
    assign in_fire     = score_valid && score_ready;
    assign has_room    = (count_reg < CNT_W'(MAX_CLASSES));
    assign new_count   = has_room ? count_reg + 1'b1 : count_reg;
    assign is_final    = (idx_reg == count_reg - 1'b1);
    assign emit_fire   = (state_reg == ST_EMIT) && (!out_valid_reg || prob_ready);
    assign div_start   = (state_reg == ST_START);
    assign div_num     = {exp_q_reg, 16'd0} + NUM_W'(sum_reg >> 1);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        max_next       = max_reg;
        idx_next       = idx_reg;
        rd_valid_next  = 1'b0;
        rd_addr_next   = rd_addr_reg;
        sum_next       = sum_reg;
        prob_next      = prob_reg;
        final_next     = final_reg;
        out_valid_next = out_valid_reg && !prob_ready;

        if (exp_res.valid)
            sum_next = sum_reg + SUM_W'(exp_res.value);

        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_fire)
                begin
                    if (has_room)
                    begin
                        count_next = new_count;
                        if ($signed(score) > $signed(max_reg))
                            max_next = score;
                    end
                    if (last)
                    begin
                        if (new_count == '0)
                        begin
                            count_next = '0;
                            max_next   = SCORE_MIN;
                        end
                        else
                        begin
                            state_next = ST_EXP;
                            idx_next   = '0;
                            sum_next   = '0;
                        end
                    end
                end
            end
            ST_EXP:
            begin
                if (idx_reg != count_reg)
                begin
                    rd_valid_next = 1'b1;
                    rd_addr_next  = idx_reg[AW-1:0];
                    idx_next      = idx_reg + 1'b1;
                end
                else if (!rd_valid_reg && !exp_busy)
                begin
                    state_next = ST_RD;
                    idx_next   = '0;
                end
            end
            ST_RD:
                state_next = ST_START;
            ST_START:
                state_next = ST_RUN;
            ST_RUN:
            begin
                if (div_stat.done)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (emit_fire)
                begin
                    prob_next      = div_quo;
                    final_next     = is_final;
                    out_valid_next = 1'b1;
                    if (is_final)
                    begin
                        state_next = ST_LOAD;
                        count_next = '0;
                        max_next   = SCORE_MIN;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_RD;
                    end
                end
            end
            default:
                state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            max_reg       <= SCORE_MIN;
            idx_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            max_reg       <= max_next;
            idx_reg       <= idx_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_addr_reg <= rd_addr_next;
        sum_reg     <= sum_next;
        prob_reg    <= prob_next;
        final_reg   <= final_next;
    end

    // score memory
    always_ff @(posedge clk)
    begin
        if (in_fire && has_room)
            score_mem[count_reg[AW-1:0]] <= score;
        score_q_reg <= score_mem[idx_reg[AW-1:0]];
    end

    // exp memory
    always_ff @(posedge clk)
    begin
        if (exp_res.valid)
            exp_mem[exp_addr] <= exp_res.value;
        exp_q_reg <= exp_mem[idx_reg[AW-1:0]];
    end

    sfn_exp_unit #(
        .AW(AW)
    ) u_exp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (rd_valid_reg),
        .in_score (score_q_reg),
        .in_max   (max_reg),
        .in_addr  (rd_addr_reg),
        .res      (exp_res),
        .res_addr (exp_addr),
        .busy     (exp_busy)
    );

    sfn_divider #(
        .SUM_W(SUM_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (div_num),
        .den      (sum_reg),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    assign prob_valid  = out_valid_reg;
    assign probability = prob_reg;
    assign final_res   = final_reg;

    a_exp_write_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
        exp_res.valid |-> (state_reg == ST_EXP))
        else $error("exp result outside exp pass");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_CLASSES))
        else $error("stored count above capacity");

    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider restarted while busy");

    a_final_returns_load: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_fire && is_final) |=> (state_reg == ST_LOAD && count_reg == '0))
        else $error("sequencer did not return to load after final result");

endmodule

// File: sim/tb_softmax_normalizer_top.sv
// self-checking testbench for softmax_normalizer_top with its own fixed-point softmax predictor
module tb_softmax_normalizer_top;
    timeunit 1ns;
    timeprecision 1ps;
    import sfn_pkg::*;

    localparam int CAPACITY = MAX_CLASSES_DEF;
    localparam int SETTLE_CYCLES = 60;
    localparam int END_WAIT_CYCLES = 40000;
    localparam logic [16:0] FRAC_POW2 [0:16] = '{
        17'd65536, 17'd62757, 17'd60097, 17'd57549, 17'd55109, 17'd52773,
        17'd50535, 17'd48393, 17'd46341, 17'd44376, 17'd42495, 17'd40693,
        17'd38968, 17'd37316, 17'd35734, 17'd34219, 17'd32768
    };

    typedef struct {
        logic [PROB_W-1:0] probability;
        logic              final_res;
    } prob_beat_t;

    logic               clk;
    logic               rst_n;
    logic               score_valid;
    logic               score_ready;
    logic [SCORE_W-1:0] score;
    logic               last;
    logic               prob_valid;
    logic               prob_ready;
    logic [PROB_W-1:0]  probability;
    logic               final_res;

    logic signed [SCORE_W-1:0] set_scores[$];
    logic signed [SCORE_W-1:0] set_max;
    prob_beat_t                prob_expect_q[$];
    int                        send_idle_pct;
    int                        recv_stall_pct;
    int                        errors;
    int                        beats_sent;
    int                        probs_checked;
    int                        sets_closed;

    softmax_normalizer_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .score_valid (score_valid),
        .score_ready (score_ready),
        .score       (score),
        .last        (last),
        .prob_valid  (prob_valid),
        .prob_ready  (prob_ready),
        .probability (probability),
        .final_res   (final_res)
    );

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint unsigned exp_neg_q88(input int unsigned x);
        longint unsigned y;
        longint unsigned n;
        int unsigned     f;
        int unsigned     h;
        int unsigned     l;
        int unsigned     m;
        y = (64'(x) * 64'(LOG2E_Q16) + 64'd32768) >> 16;
        n = y >> 8;
        f = int'(y & 64'd255);
        h = f >> 4;
        l = f & 15;
        m = FRAC_POW2[h] - (((FRAC_POW2[h] - FRAC_POW2[h + 1]) * l) >> 4);
        if (n >= 32)
            return 0;
        return 64'(m >> n);
    endfunction

    function automatic void predict_probabilities();
        longint unsigned e[$];
        longint unsigned total;
        longint unsigned p;
        prob_beat_t      b;
        int unsigned     x;
        total = 0;
        foreach (set_scores[i])
        begin
            x = int'(set_max) - int'(set_scores[i]);
            e.push_back(exp_neg_q88(x));
            total += e[i];
        end
        foreach (e[i])
        begin
            p = ((e[i] << 16) + (total >> 1)) / total;
            if (p > 65535)
                p = 65535;
            b.probability = p[PROB_W-1:0];
            b.final_res = (i == e.size() - 1);
            prob_expect_q.push_back(b);
        end
        set_scores.delete();
        set_max = SCORE_MIN;
        sets_closed++;
    endfunction

    function automatic void accept_score(input logic signed [SCORE_W-1:0] s, input logic lst);
        if (set_scores.size() < CAPACITY)
        begin
            set_scores.push_back(s);
            if (s > set_max)
                set_max = s;
        end
        if (lst)
            predict_probabilities();
    endfunction

    task automatic send_score(input logic [SCORE_W-1:0] s, input logic lst);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            score_valid <= 1'b0;
            @(negedge clk);
        end
        score_valid <= 1'b1;
        score <= s;
        last <= lst;
        @(posedge clk);
        while (!score_ready)
            @(posedge clk);
        accept_score(s, lst);
        beats_sent++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        score_valid <= 1'b0;
        while (prob_expect_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        wait_drained();
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    function automatic logic [SCORE_W-1:0] clamp_score(input int v);
        if (v > 32767)
            return 16'h7fff;
        if (v < -32768)
            return 16'h8000;
        return v[SCORE_W-1:0];
    endfunction

    function automatic logic [SCORE_W-1:0] pick_score(input int mode, input int base,
                                                      input int spread);
        case (mode)
            0: return 16'($urandom);
            1: return clamp_score(base - int'($urandom_range(spread)));
            default:
                case ($urandom_range(4))
                    0: return 16'h8000;
                    1: return 16'h7fff;
                    2: return 16'h0000;
                    3: return 16'hffff;
                    default: return 16'($urandom);
                endcase
        endcase
    endfunction

    task automatic send_random_set(input int len, output int stored);
        int mode;
        int base;
        int spread;
        mode = ($urandom_range(9) < 6) ? 1 : (($urandom_range(1) == 0) ? 0 : 2);
        base = int'($signed(16'($urandom)));
        case ($urandom_range(3))
            0: spread = 16;
            1: spread = 256;
            2: spread = 2048;
            default: spread = 8192;
        endcase
        stored = (len > CAPACITY) ? CAPACITY : len;
        for (int i = 0; i < len; i++)
            send_score(pick_score(mode, base, spread), i == len - 1);
    endtask

    task automatic test_lone_score();
        send_score(16'sd100, 1'b1);
        send_score(16'h8000, 1'b1);
    endtask

    task automatic test_extremes();
        send_score(16'h7fff, 1'b0);
        send_score(16'h8000, 1'b1);
        send_score(16'h8000, 1'b0);
        send_score(16'h7fff, 1'b1);
    endtask

    task automatic test_equal_scores();
        repeat (3) send_score(16'h1234, 1'b0);
        send_score(16'h1234, 1'b1);
    endtask

    task automatic test_exp_table();
        send_score(16'sd0, 1'b0);
        send_score(-16'sd1, 1'b0);
        send_score(-16'sd16, 1'b0);
        send_score(-16'sd100, 1'b0);
        send_score(-16'sd256, 1'b0);
        send_score(-16'sd2048, 1'b0);
        send_score(-16'sd5677, 1'b0);
        send_score(-16'sd5678, 1'b0);
        send_score(16'sd0, 1'b1);
    endtask

    task automatic test_capacity();
        int stored;
        send_random_set(CAPACITY + 2, stored);
    endtask

    task automatic test_random_sets(input int beats);
        int done;
        int len;
        int stored;
        done = 0;
        while (done < beats)
        begin
            case ($urandom_range(19))
                0:       len = $urandom_range(CAPACITY + 3, 17);
                1, 2, 3: len = $urandom_range(16, 7);
                default: len = $urandom_range(6, 1);
            endcase
            send_random_set(len, stored);
            done += stored;
        end
    endtask

    always @(negedge clk)
        prob_ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        prob_beat_t want;
        if (rst_n && prob_valid && prob_ready)
        begin
            if (prob_expect_q.size() == 0)
            begin
                $error("unexpected beat: probability %0d final_res %0b", probability, final_res);
                errors++;
            end
            else
            begin
                want = prob_expect_q.pop_front();
                probs_checked++;
                if (probability !== want.probability)
                begin
                    $error("probability: expected %0d, got %0d", want.probability, probability);
                    errors++;
                end
                if (final_res !== want.final_res)
                begin
                    $error("final_res: expected %0b, got %0b", want.final_res, final_res);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #3ms;
        $display("softmax_normalizer_top: mismatch");
        $finish;
    end

    initial
    begin
        int waited;
        rst_n = 1'b0;
        score_valid = 1'b0;
        score = '0;
        last = 1'b0;
        prob_ready = 1'b0;
        set_max = SCORE_MIN;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        errors = 0;
        beats_sent = 0;
        probs_checked = 0;
        sets_closed = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_lone_score();
        test_extremes();
        test_equal_scores();
        test_exp_table();

        set_idling(63, 0);
        test_random_sets(12);
        set_idling(0, 63);
        test_capacity();
        test_random_sets(12);
        set_idling(16, 16);
        test_random_sets(12);
        set_idling(0, 0);
        test_random_sets(12);

        @(negedge clk);
        score_valid <= 1'b0;
        waited = 0;
        while (prob_expect_q.size() != 0 && waited < END_WAIT_CYCLES)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (prob_expect_q.size() != 0)
        begin
            $error("%0d expected probabilities never arrived", prob_expect_q.size());
            errors++;
        end

        $display("sent %0d score beats in %0d sets, checked %0d probabilities",
                 beats_sent, sets_closed, probs_checked);
        $display("covered saturation, extremes, exp table steps, dropped scores and idling mixes");
        if (errors == 0)
            $display("softmax_normalizer_top: match");
        else
            $display("softmax_normalizer_top: mismatch");
        $finish;
    end

endmodule

// File: softmax_normalizer_top.f
src/sfn_pkg.sv
src/sfn_exp_unit.sv
src/sfn_divider.sv
src/softmax_normalizer_top.sv
sim/tb_softmax_normalizer_top.sv
